### design/bounded_substring_search_defines.svh
// Assertion macros for the bounded substring search block.
// Used by design/bounded_substring_search.sv; relies on clk and arst_n in scope.
`ifndef BOUNDED_SUBSTRING_SEARCH_DEFINES_SVH
`define BOUNDED_SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, reset disables the check.
`define BSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset disables the check.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bss_pkg.sv
// Shared types and constants of the bounded substring search block.
// No dependencies; used by bss_match and bounded_substring_search.
package bss_pkg;

	// query register holds up to 16 bytes; length field is 5 bits
	localparam int QUERY_REG_BYTES = 16;
	localparam int LEN_W           = 5;

	typedef enum logic [1:0] {
		STATUS_SEARCHING = 2'd0,
		STATUS_FOUND     = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_IDLE      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_QUERY_LENGTH = 2'd0,
		CFG_QUERY_LOW    = 2'd1,
		CFG_QUERY_HIGH   = 2'd2,
		CFG_SEARCH_LIMIT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;  // effective query length
		logic             hit;  // window ends with the query (len >= 1)
	} match_t;

endpackage

### design/bss_match.sv
// Window comparator: effective query length and diagonal byte compares.
// Depends on bss_pkg.
module bss_match import bss_pkg::*; #(
	parameter int WIN = 16
) (
	input  logic [WIN-1:0][7:0]             window,
	input  logic [QUERY_REG_BYTES-1:0][7:0] query,
	input  logic [LEN_W-1:0]                query_length,
	output match_t                          result
);

	logic [LEN_W-1:0] lim;
	logic [LEN_W-1:0] len;
	logic [WIN:0]     diag;
	logic             hit;

	// clamp to window size, then stop at the first zero query byte
	always_comb begin
		lim = (query_length > LEN_W'(WIN)) ? LEN_W'(WIN) : query_length;
		len = lim;
		for (int k = WIN - 1; k >= 0; k--) begin
			if (LEN_W'(k) < lim && query[k] == 8'd0) begin
				len = LEN_W'(k);
			end
		end
	end

	// diag[L]: newest L bytes equal query bytes 0..L-1 (oldest first)
	always_comb begin
		diag = '0;
		for (int l = 1; l <= WIN; l++) begin
			diag[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (window[l-1-k] != query[k]) begin
					diag[l] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int l = 1; l <= WIN; l++) begin
			if (len == LEN_W'(l)) begin
				hit = diag[l];
			end
		end
	end

	assign result.len = len;
	assign result.hit = hit;

endmodule

### design/bounded_substring_search.sv
// Bounded substring search over a byte stream, top level.
// Depends on bss_pkg, bss_match and bounded_substring_search_defines.svh.
//
//  channel   direction  handshake                   payload
//  text      in         text_valid / text_ready     text_byte, first_byte
//  result    out        result_valid / result_ready status, match_index
//  cfg       in         cfg_write (no wait)         cfg_index, cfg_data
//
// One result transaction per text transaction, one byte per cycle sustained while
// result_ready stays high. The accepting edge loads the input register; compare
// logic then feeds the result register, which loads once it is free. The
// window comparators (up to 16 bytes) and the limit compares sit in that one stage.
// Reset needs no clearing pass; the block is idle until a first byte.
// A stalled result register holds the compute stage, which then holds the
// input register.
`include "bounded_substring_search_defines.svh"

module bounded_substring_search import bss_pkg::*; #(
	parameter int QUERY_MAX     = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        first_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [31:0] match_index,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// only the newest min(QUERY_MAX, 16) bytes can take part in a match
	localparam int WIN   = (QUERY_MAX < QUERY_REG_BYTES) ? QUERY_MAX : QUERY_REG_BYTES;
	localparam int CMP_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	// configuration registers
	logic [LEN_W-1:0] query_length_q;
	logic [63:0]      query_low_q;
	logic [63:0]      query_high_q;
	logic [31:0]      search_limit_q;

	// search state
	logic [WIN-1:0][7:0]        recent_q;
	logic [POSITION_BITS-1:0]   pos_q;
	logic                       concluded_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] index_q;

	logic                     out_free;
	logic                     advance;
	logic [WIN-1:0][7:0]      rec_eff;
	logic [WIN-1:0][7:0]      window;
	logic [POSITION_BITS-1:0] pos_eff;
	logic                     conc_eff;
	match_t                   mres;
	logic [CMP_W-1:0]         p_ext;
	logic [CMP_W-1:0]         n_ext;
	logic [CMP_W-1:0]         len_ext;
	logic [CMP_W-1:0]         start_ext;
	status_t                  res_status;
	logic [31:0]              res_index;

	//----------------------------------------------------------------
	// configuration port
	//----------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= '0;
			query_low_q    <= '0;
			query_high_q   <= '0;
			search_limit_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_QUERY_LENGTH: query_length_q <= cfg_data[LEN_W-1:0];
				CFG_QUERY_LOW:    query_low_q    <= cfg_data;
				CFG_QUERY_HIGH:   query_high_q   <= cfg_data;
				CFG_SEARCH_LIMIT: search_limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	//----------------------------------------------------------------
	// handshake: stage 1 moves when the result register can take it
	//----------------------------------------------------------------
	assign out_free   = !out_valid_q || result_ready;
	assign advance    = valid_s1 && out_free;
	assign text_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			byte_s1  <= text_byte;
			first_s1 <= first_byte;
		end
	end

	//----------------------------------------------------------------
	// compute: a first byte restarts from a cleared state
	//----------------------------------------------------------------
	assign rec_eff  = first_s1 ? '0 : recent_q;
	assign pos_eff  = first_s1 ? '0 : pos_q;
	assign conc_eff = first_s1 ? 1'b0 : concluded_q;

	// shifted window, newest byte at index 0
	always_comb begin
		window[0] = byte_s1;
		for (int j = 1; j < WIN; j++) begin
			window[j] = rec_eff[j-1];
		end
	end

	bss_match #(
		.WIN (WIN)
	) u_match (
		.window       (window),
		.query        ({query_high_q, query_low_q}),
		.query_length (query_length_q),
		.result       (mres)
	);

	assign p_ext     = CMP_W'(pos_eff);
	assign n_ext     = CMP_W'(search_limit_q);
	assign len_ext   = CMP_W'(mres.len);
	assign start_ext = p_ext - len_ext + CMP_W'(1);

	always_comb begin
		res_status = STATUS_SEARCHING;
		res_index  = '0;
		if (conc_eff) begin
			res_status = STATUS_IDLE;
		end else if (byte_s1 == 8'd0) begin
			res_status = STATUS_NOT_FOUND;
		end else if (mres.len == '0) begin
			// empty query matches at the current position
			res_status = STATUS_FOUND;
			res_index  = p_ext[31:0];
		end else if (len_ext > n_ext) begin
			res_status = STATUS_NOT_FOUND;
		end else if (mres.hit && p_ext >= len_ext - CMP_W'(1) && p_ext < n_ext) begin
			res_status = STATUS_FOUND;
			res_index  = start_ext[31:0];
		end else if (n_ext == '0 || p_ext >= n_ext - CMP_W'(1)) begin
			// last byte inside the limit checked without a hit
			res_status = STATUS_NOT_FOUND;
		end
	end

	//----------------------------------------------------------------
	// state update: untouched by a byte that arrives after conclusion
	//----------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q    <= '0;
			pos_q       <= '0;
			concluded_q <= 1'b1;
		end else if (advance && !conc_eff) begin
			recent_q    <= window;
			pos_q       <= (pos_eff == POS_MAX) ? pos_eff : pos_eff + POSITION_BITS'(1);
			concluded_q <= (res_status != STATUS_SEARCHING);
		end
	end

	//----------------------------------------------------------------
	// result register
	//----------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= res_status;
			index_q  <= res_index;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign match_index  = index_q;

	//----------------------------------------------------------------
	// checks
	//----------------------------------------------------------------
	`BSS_ASSERT_NOW(a_index_only_on_found, result_valid && status_q != STATUS_FOUND, index_q == '0, "match_index nonzero without found status")
	`BSS_ASSERT_NEXT(a_idle_keeps_state, advance && conc_eff, $stable(pos_q) && $stable(recent_q), "state changed after conclusion")
	`BSS_ASSERT_NEXT(a_conclusion_sticks, advance && res_status != STATUS_SEARCHING, concluded_q, "search not concluded after final status")

endmodule
